/* hw/rtl/srtds_pkg.sv */
package srtds_pkg;

   // Width of the shared divider: the clock register and the quotient a.
   localparam int unsigned DIV_WIDTH = 28;
   localparam int unsigned MAG_WIDTH = 26;
   // Candidate divisors stop at floor(sqrt(a)) < 2^14, so the counter needs one more bit.
   localparam int unsigned CAND_WIDTH = 15;
   localparam int unsigned SQ_WIDTH = 29;

   localparam logic [DIV_WIDTH-1:0] CLOCK_RESET = 28'd84000000;
   localparam logic [MAG_WIDTH-1:0] FAST_RATE = 26'd1000;
   localparam logic [MAG_WIDTH-1:0] SINE_FLOOR = 26'd100;

   localparam logic [1:0] STATUS_APPLIED = 2'd0;
   localparam logic [1:0] STATUS_HELD = 2'd1;
   localparam logic [1:0] STATUS_SKIPPED = 2'd2;
   localparam logic [1:0] STATUS_INVALID = 2'd3;

   localparam logic OPCODE_SINE = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_DIV_A,
      S_CHECK,
      S_DIV_D,
      S_DONE
   } state_type;

endpackage

/* hw/rtl/srtds_div.sv */
module srtds_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [srtds_pkg::DIV_WIDTH-1:0]     dividend,
   input  logic [srtds_pkg::DIV_WIDTH-1:0]     divisor,
   output logic                                done,
   output logic [srtds_pkg::DIV_WIDTH-1:0]     quotient,
   output logic [srtds_pkg::DIV_WIDTH-1:0]     remainder
);

   localparam int unsigned W = srtds_pkg::DIV_WIDTH;
   localparam int unsigned CW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [W:0]    shifted;
   logic [W:0]    trial;

   // Restoring division, one quotient bit per cycle. The dividend shifts out of
   // the top of the quotient register while quotient bits enter at the bottom.
   always_comb begin
      shifted  = {rem_ff, quo_ff[W-1]};
      trial    = shifted - {1'b0, dsr_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CW'(W - 1);
         rem_in   = '0;
         quo_in   = dividend;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         if (trial[W]) begin
            rem_in = shifted[W-1:0];
         end else begin
            rem_in = trial[W-1:0];
         end
         quo_in = {quo_ff[W-2:0], ~trial[W]};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dsr_ff   <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* hw/rtl/step_rate_timer_divisor_search.sv */
// A skipped or zero request goes from load straight to the response. Otherwise the search
// tries N candidate divisors and stops early on an exact divisor,
// where N is the number of candidates tried (2 up to floor(sqrt(a)), at most 16382).
// Every division goes through one shared restoring divider at one quotient bit per cycle.
// Throughput: one item at a time; req_tready is high only in idle, which is entered as the
// result is written to the output register, where it may wait while the next item is taken.
// Reset (synchronous, active high) sets clock_hz to 84000000 and clears direction and timer state.
module step_rate_timer_divisor_search #(
   parameter int unsigned PERIOD_LIMIT = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // rate_request [25:0], counter_now [41:26], zero fill
   input  logic        req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // period_value [15:0], prescale_value [31:16],
                                    // dir_pin [32], dir_changed [33], reloaded [34], zero fill
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_wr_en,
   input  logic [27:0] csr_wr_data  // clock_hz
);

   localparam int unsigned DW = srtds_pkg::DIV_WIDTH;
   localparam int unsigned MW = srtds_pkg::MAG_WIDTH;
   localparam int unsigned CW = srtds_pkg::CAND_WIDTH;
   localparam int unsigned SW = srtds_pkg::SQ_WIDTH;
   localparam logic [DW:0] LIMIT_Q = (DW + 1)'(PERIOD_LIMIT);

   srtds_pkg::state_type state_ff, state_in;

   logic [DW-1:0] clock_hz_ff, clock_hz_in;
   logic          skip_ff, skip_in;
   logic [MW-1:0] mag_ff, mag_in;
   logic [15:0]   counter_ff, counter_in;
   logic          flag_ff, flag_in;
   logic [DW-1:0] a_ff, a_in;
   logic [CW-1:0] d_ff, d_in;
   logic [SW-1:0] sq_ff, sq_in;
   logic          found_ff, found_in;
   logic [CW-1:0] best_rem_ff, best_rem_in;
   logic [CW-1:0] best_div_ff, best_div_in;
   logic [15:0]   best_q_ff, best_q_in;
   logic          last_dir_ff, last_dir_in;
   logic [15:0]   cur_period_ff, cur_period_in;
   logic [15:0]   cur_prescale_ff, cur_prescale_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [39:0]   rsp_data_ff, rsp_data_in;
   logic [1:0]    rsp_user_ff, rsp_user_in;

   logic          req_accept;
   logic          div_start;
   logic [DW-1:0] div_dividend;
   logic [DW-1:0] div_divisor;
   logic          div_done;
   logic [DW-1:0] div_quo;
   logic [DW-1:0] div_rem;
   logic          out_load;
   logic          in_range;
   logic          candidate;
   logic          exact_hit;

   logic [MW-1:0] raw_rate;
   logic [MW-1:0] raw_mag;

   srtds_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign raw_rate   = req_tdata[25:0];
   assign raw_mag    = raw_rate[MW-1] ? (MW'(0) - raw_rate) : raw_rate;
   assign req_accept = req_tvalid && req_tready;
   assign in_range   = (SW'(d_ff) * SW'(d_ff) <= SW'(a_ff)) ? 1'b1 : 1'b0;

   // A candidate wins with a period that fits and, once one is found, only with a strictly smaller remainder.
   assign candidate = ({1'b0, div_quo} < LIMIT_Q)
                      && (!found_ff || (div_rem[CW-1:0] < best_rem_ff));
   assign exact_hit = candidate && (div_rem == '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srtds_pkg::S_IDLE: begin
            if (req_accept) state_in = srtds_pkg::S_LOAD;
         end
         srtds_pkg::S_LOAD: begin
            if (skip_ff || mag_ff == '0) begin
               state_in = srtds_pkg::S_DONE;
            end else begin
               state_in = srtds_pkg::S_DIV_A;
            end
         end
         srtds_pkg::S_DIV_A: begin
            if (div_done) state_in = srtds_pkg::S_CHECK;
         end
         srtds_pkg::S_CHECK: begin
            if (sq_ff <= SW'(a_ff)) begin
               state_in = srtds_pkg::S_DIV_D;
            end else begin
               state_in = srtds_pkg::S_DONE;
            end
         end
         srtds_pkg::S_DIV_D: begin
            if (div_done) begin
               state_in = exact_hit ? srtds_pkg::S_DONE : srtds_pkg::S_CHECK;
            end
         end
         srtds_pkg::S_DONE: begin
            if (out_load) state_in = srtds_pkg::S_IDLE;
         end
         default: state_in = srtds_pkg::S_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready   = 1'b0;
      div_start    = 1'b0;
      div_dividend = a_ff;
      div_divisor  = DW'(d_ff);
      out_load     = 1'b0;
      case (state_ff)
         srtds_pkg::S_IDLE: req_tready = 1'b1;
         srtds_pkg::S_LOAD: begin
            div_start    = !skip_ff && (mag_ff != '0);
            div_dividend = clock_hz_ff;
            div_divisor  = DW'(mag_ff);
         end
         srtds_pkg::S_CHECK: div_start = (sq_ff <= SW'(a_ff));
         srtds_pkg::S_DONE: out_load = !rsp_valid_ff || rsp_tready;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Datapath.
   always_comb begin
      logic [15:0] period_new;
      logic [15:0] prescale_new;
      logic        apply;
      logic [1:0]  status;
      logic        changed;
      logic        reload;

      clock_hz_in     = csr_wr_en ? csr_wr_data : clock_hz_ff;
      skip_in         = skip_ff;
      mag_in          = mag_ff;
      counter_in      = counter_ff;
      flag_in         = flag_ff;
      a_in            = a_ff;
      d_in            = d_ff;
      sq_in           = sq_ff;
      found_in        = found_ff;
      best_rem_in     = best_rem_ff;
      best_div_in     = best_div_ff;
      best_q_in       = best_q_ff;
      last_dir_in     = last_dir_ff;
      cur_period_in   = cur_period_ff;
      cur_prescale_in = cur_prescale_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_user_in     = rsp_user_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;

      period_new   = best_q_ff - 16'd1;
      prescale_new = 16'({1'b0, best_div_ff} - 16'd1);
      apply        = (mag_ff > srtds_pkg::FAST_RATE) || (counter_ff > (cur_period_ff >> 1));
      status       = srtds_pkg::STATUS_HELD;
      changed      = 1'b0;
      reload       = 1'b0;

      if (req_accept) begin
         mag_in     = raw_mag;
         counter_in = req_tdata[41:26];
         flag_in    = ~raw_rate[MW-1];
         skip_in    = (req_tuser == srtds_pkg::OPCODE_SINE) && (raw_mag < srtds_pkg::SINE_FLOOR);
         found_in   = 1'b0;
      end

      if (state_ff == srtds_pkg::S_DIV_A && div_done) begin
         a_in  = div_quo;
         d_in  = CW'(2);
         sq_in = SW'(4);
      end

      if (state_ff == srtds_pkg::S_DIV_D && div_done) begin
         if (candidate) begin
            found_in    = 1'b1;
            best_rem_in = div_rem[CW-1:0];
            best_div_in = d_ff;
            best_q_in   = div_quo[15:0];
         end
         // (d+1)^2 = d^2 + 2d + 1
         d_in  = d_ff + 1'b1;
         sq_in = sq_ff + SW'({d_ff, 1'b1});
      end

      if (out_load) begin
         if (skip_ff) begin
            status = srtds_pkg::STATUS_SKIPPED;
         end else if (!found_ff) begin
            status = srtds_pkg::STATUS_INVALID;
         end else if (apply) begin
            status      = srtds_pkg::STATUS_APPLIED;
            changed     = flag_ff != last_dir_ff;
            last_dir_in = flag_ff;
            if (period_new != cur_period_ff || prescale_new != cur_prescale_ff) begin
               reload          = 1'b1;
               cur_period_in   = period_new;
               cur_prescale_in = prescale_new;
            end
         end
         if (status inside {srtds_pkg::STATUS_SKIPPED, srtds_pkg::STATUS_INVALID}) begin
            period_new   = '0;
            prescale_new = '0;
         end
         rsp_valid_in = 1'b1;
         rsp_user_in  = status;
         rsp_data_in  = {5'd0, reload, changed, ~last_dir_in, prescale_new, period_new};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= srtds_pkg::S_IDLE;
         clock_hz_ff     <= srtds_pkg::CLOCK_RESET;
         last_dir_ff     <= 1'b0;
         cur_period_ff   <= '0;
         cur_prescale_ff <= '0;
         rsp_valid_ff    <= 1'b0;
         found_ff        <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clock_hz_ff     <= clock_hz_in;
         last_dir_ff     <= last_dir_in;
         cur_period_ff   <= cur_period_in;
         cur_prescale_ff <= cur_prescale_in;
         rsp_valid_ff    <= rsp_valid_in;
         found_ff        <= found_in;
      end
      skip_ff     <= skip_in;
      mag_ff      <= mag_in;
      counter_ff  <= counter_in;
      flag_ff     <= flag_in;
      a_ff        <= a_in;
      d_ff        <= d_in;
      sq_ff       <= sq_in;
      best_rem_ff <= best_rem_in;
      best_div_ff <= best_div_in;
      best_q_ff   <= best_q_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef NO_ASSERTIONS
   // The running square tracks the candidate divisor exactly.
   a_square_tracks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srtds_pkg::S_CHECK) |-> (sq_ff == SW'(d_ff) * SW'(d_ff)))
      else $error("candidate square out of step with divisor");

   // Only a divisor of at least two is ever recorded as found.
   a_found_div: assert property (@(posedge clock) disable iff (reset)
      found_ff && state_ff != srtds_pkg::S_IDLE && state_ff != srtds_pkg::S_LOAD
      |-> (best_div_ff >= CW'(2)))
      else $error("recorded divisor below two");

   // The divider is started only for a candidate inside the search range.
   a_start_in_range: assert property (@(posedge clock) disable iff (reset)
      div_start && state_ff == srtds_pkg::S_CHECK |-> in_range)
      else $error("divider started beyond the square root");

   // A reload or direction change is reported only for an applied setting.
   a_reload_applied: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff[34] || rsp_data_ff[33])
      |-> (rsp_user_ff == srtds_pkg::STATUS_APPLIED))
      else $error("reload or direction change without applying");

   // An accepted item blocks the input until its result is written.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("input taken while an item is in work");
`endif

endmodule
